// ===== rtl/box_circle_pair_collision_test_core_assert.svh =====
// assertion macros used by the checker file bcpc_checker.sv
`ifndef BOX_CIRCLE_PAIR_COLLISION_TEST_CORE_ASSERT_SVH
`define BOX_CIRCLE_PAIR_COLLISION_TEST_CORE_ASSERT_SVH

// clocked assertion, switched off while reset is high
`define BCPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bcpc assertion failed");

// clocked assertion that also holds during reset
`define BCPC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bcpc reset assertion failed");

`endif

// ===== rtl/bcpc_pkg.sv =====
// ---------------------------------------------------------------------------
// bcpc_pkg
// Shared types and constants of the box / circle pair collision test.
// ---------------------------------------------------------------------------
package bcpc_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 16;

  // width of box sizes and radii
  localparam int SIZE_BITS = 15;

  // any distance component above this already rules out a hit
  localparam int FAR_LIMIT = 65536;

  // magnitude width after the far-apart cut
  localparam int MAG_BITS = 17;

  // test chosen for a pair
  typedef enum logic [1:0] {
    KIND_BOX_BOX       = 2'd0,
    KIND_BOX_CIRCLE    = 2'd1,
    KIND_CIRCLE_CIRCLE = 2'd2
  } pair_kind_t;

endpackage

// ===== rtl/box_circle_pair_collision_test_core.sv =====
// ---------------------------------------------------------------------------
// box_circle_pair_collision_test_core
// Intersection test of two shapes, each an axis-aligned box or a circle.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries one shape pair per item; the
//   item is taken at a rising edge with in_valid high and in_stall low.
//   Output channel out_valid / out_stall carries overlap_hit and pair_kind,
//   one result item per input item, in order.
//   Four register stages: role selection and edge differences, nearest-edge
//   distance and magnitude, squaring, then sum and compare into the output
//   register. An accepted item passes stage registers 1 to 3 and then sets
//   out_valid; one item is accepted every cycle while the output is taken.
//   When out_stall is high the output holds; upstream stages keep filling
//   empty slots, and in_stall rises only once every stage holds an item.
//   Reset (rst, synchronous) empties all stages; no result is lost or
//   repeated across a stall.
//   COORD_BITS sets the coordinate port width; the arithmetic widens to
//   cover it, and the squarers stay 17 by 17 bits.
// ---------------------------------------------------------------------------
module box_circle_pair_collision_test_core #(
  parameter int COORD_BITS = bcpc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                first_is_circle,
  input  logic signed [COORD_BITS-1:0]        first_x,
  input  logic signed [COORD_BITS-1:0]        first_y,
  input  logic [bcpc_pkg::SIZE_BITS-1:0]      first_width,
  input  logic [bcpc_pkg::SIZE_BITS-1:0]      first_height,
  input  logic [bcpc_pkg::SIZE_BITS-1:0]      first_radius,
  input  logic                                second_is_circle,
  input  logic signed [COORD_BITS-1:0]        second_x,
  input  logic signed [COORD_BITS-1:0]        second_y,
  input  logic [bcpc_pkg::SIZE_BITS-1:0]      second_width,
  input  logic [bcpc_pkg::SIZE_BITS-1:0]      second_height,
  input  logic [bcpc_pkg::SIZE_BITS-1:0]      second_radius,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                overlap_hit,
  output bcpc_pkg::pair_kind_t                pair_kind
);
  import bcpc_pkg::*;

  // working width: the wider of coordinate and signed box size, plus two bits of room
  localparam int W       = ((COORD_BITS > SIZE_BITS + 1) ? COORD_BITS : SIZE_BITS + 1) + 2;
  localparam int RR_BITS = SIZE_BITS + 1;
  localparam int SQ_BITS = 2 * MAG_BITS;
  localparam int RS_BITS = 2 * RR_BITS;

  // widened inputs
  logic signed [W-1:0] x1e, y1e, w1e, h1e, x2e, y2e, w2e, h2e;

  assign x1e = W'(first_x);
  assign y1e = W'(first_y);
  assign x2e = W'(second_x);
  assign y2e = W'(second_y);
  assign w1e = $signed(W'(first_width));
  assign h1e = $signed(W'(first_height));
  assign w2e = $signed(W'(second_width));
  assign h2e = $signed(W'(second_height));

  // stage handshake: a stage loads when it is empty or its successor moves
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  // stage 1 logic: roles, edge differences, radius, box-box overlap
  logic signed [W-1:0]  cx, cy, bx, by, bw, bh;
  logic [RR_BITS-1:0]   rr_sel;
  pair_kind_t           kind_sel;
  logic signed [W-1:0]  dlox_n, dhix_n, dloy_n, dhiy_n;
  logic                 bb_n;

  always_comb begin
    if (first_is_circle) begin
      cx     = x1e;
      cy     = y1e;
      bx     = x2e;
      by     = y2e;
      bw     = w2e;
      bh     = h2e;
      rr_sel = RR_BITS'(first_radius);
    end else begin
      cx     = x2e;
      cy     = y2e;
      bx     = x1e;
      by     = y1e;
      bw     = w1e;
      bh     = h1e;
      rr_sel = RR_BITS'(second_radius);
    end

    if (first_is_circle && second_is_circle) begin
      kind_sel = KIND_CIRCLE_CIRCLE;
      rr_sel   = RR_BITS'(first_radius) + RR_BITS'(second_radius);
      dlox_n   = x1e - x2e;
      dhix_n   = x1e - x2e;
      dloy_n   = y1e - y2e;
      dhiy_n   = y1e - y2e;
    end else begin
      kind_sel = (first_is_circle || second_is_circle) ? KIND_BOX_CIRCLE : KIND_BOX_BOX;
      dlox_n   = cx - bx;
      dhix_n   = cx - bx - bw;
      dloy_n   = cy - by;
      dhiy_n   = cy - by - bh;
    end

    bb_n = (x1e < x2e + w2e) && (x1e + w1e > x2e) &&
           (y1e < y2e + h2e) && (y1e + h1e > y2e);
  end

  // stage 1 registers
  pair_kind_t           kind1;
  logic signed [W-1:0]  dlox1, dhix1, dloy1, dhiy1;
  logic [RR_BITS-1:0]   rr1;
  logic                 bb1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      kind1 <= kind_sel;
      dlox1 <= dlox_n;
      dhix1 <= dhix_n;
      dloy1 <= dloy_n;
      dhiy1 <= dhiy_n;
      rr1   <= rr_sel;
      bb1   <= bb_n;
    end
  end

  // stage 2 logic: nearest-edge distance per axis
  logic [MAG_BITS-1:0] ax_n, ay_n;
  logic                farx_n, fary_n;

  bcpc_axis_sep #(.W(W)) u_sep_x (
    .dlo (dlox1),
    .dhi (dhix1),
    .mag (ax_n),
    .far (farx_n)
  );

  bcpc_axis_sep #(.W(W)) u_sep_y (
    .dlo (dloy1),
    .dhi (dhiy1),
    .mag (ay_n),
    .far (fary_n)
  );

  // stage 2 registers
  pair_kind_t          kind2;
  logic [MAG_BITS-1:0] ax2, ay2;
  logic                far2;
  logic [RR_BITS-1:0]  rr2;
  logic                bb2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      kind2 <= kind1;
      ax2   <= ax_n;
      ay2   <= ay_n;
      far2  <= farx_n || fary_n;
      rr2   <= rr1;
      bb2   <= bb1;
    end
  end

  // stage 3 registers: squares
  pair_kind_t          kind3;
  logic [SQ_BITS-1:0]  sqx3, sqy3;
  logic [RS_BITS-1:0]  rsq3;
  logic                far3;
  logic                bb3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      kind3 <= kind2;
      sqx3  <= SQ_BITS'(ax2) * SQ_BITS'(ax2);
      sqy3  <= SQ_BITS'(ay2) * SQ_BITS'(ay2);
      rsq3  <= RS_BITS'(rr2) * RS_BITS'(rr2);
      far3  <= far2;
      bb3   <= bb2;
    end
  end

  // stage 4 logic: squared distance against squared radius
  logic [SQ_BITS:0] dist_sq;
  logic             hit_n;

  assign dist_sq = (SQ_BITS + 1)'(sqx3) + (SQ_BITS + 1)'(sqy3);

  always_comb begin
    if (kind3 == KIND_BOX_BOX) begin
      hit_n = bb3;
    end else begin
      hit_n = !far3 && (dist_sq < (SQ_BITS + 1)'(rsq3));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= v3;
    end
    if (rdy4 && v3) begin
      overlap_hit <= hit_n;
      pair_kind   <= kind3;
    end
  end

endmodule

// ===== rtl/bcpc_axis_sep.sv =====
// ---------------------------------------------------------------------------
// bcpc_axis_sep
// Separation of a point from an interval on one axis: picks the distance to
// the nearer edge (or zero inside), takes its magnitude and flags far values.
// ---------------------------------------------------------------------------
module bcpc_axis_sep #(
  parameter int W = 18
) (
  input  logic signed [W-1:0]            dlo,
  input  logic signed [W-1:0]            dhi,
  output logic [bcpc_pkg::MAG_BITS-1:0]  mag,
  output logic                           far
);
  import bcpc_pkg::*;

  logic signed [W-1:0] d;
  logic [W-1:0]        a;

  // below the low edge, above the high edge, or inside
  always_comb begin
    if (dlo < 0) begin
      d = dlo;
    end else if (dhi > 0) begin
      d = dhi;
    end else begin
      d = '0;
    end
  end

  // magnitude and far-apart cut
  assign a   = (d < 0) ? W'(-d) : W'(d);
  assign far = (a > W'(FAR_LIMIT));
  assign mag = far ? '0 : a[MAG_BITS-1:0];

endmodule

// ===== rtl/bcpc_checker.sv =====
// ---------------------------------------------------------------------------
// bcpc_checker
// Port-level checks of the collision test core, bound to the top level.
// ---------------------------------------------------------------------------
`include "box_circle_pair_collision_test_core_assert.svh"

module bcpc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // a stalled result stays offered
  `BCPC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)

  // input back-pressure only comes from a blocked output
  `BCPC_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall)

  // with the output free, an accepted item passes the stages and shows up at the output
  `BCPC_ASSERT(a_latency,
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)

  // reset empties the pipeline
  `BCPC_ASSERT_RST(a_reset_empty, rst |=> !out_valid)

endmodule

bind box_circle_pair_collision_test_core bcpc_checker u_bcpc_checker (.*);

// ===== tb/box_circle_pair_collision_test_core_test.sv =====
// ---------------------------------------------------------------------------
// box_circle_pair_collision_test_core_test
// Streams shape pairs (box-box, box-circle both ways, circle-circle) through
// the collision core and checks each result item against a predictor kept in
// the testbench. It covers edge-touching and zero-size corners, the widest
// coordinates, random traffic under three idle mixes, a long output hold-off
// and a full drain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_circle_pair_collision_test_core_test;
  import bcpc_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int SW = SIZE_BITS;

  typedef struct {
    logic                 is_circle;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [SW-1:0]        width;
    logic [SW-1:0]        height;
    logic [SW-1:0]        radius;
  } shape_t;

  typedef struct {
    shape_t a;
    shape_t b;
  } shape_pair_t;

  typedef struct {
    logic       hit;
    pair_kind_t kind;
  } collision_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 first_is_circle;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic [SW-1:0]        first_width;
  logic [SW-1:0]        first_height;
  logic [SW-1:0]        first_radius;
  logic                 second_is_circle;
  logic signed [CW-1:0] second_x;
  logic signed [CW-1:0] second_y;
  logic [SW-1:0]        second_width;
  logic [SW-1:0]        second_height;
  logic [SW-1:0]        second_radius;
  logic                 out_valid;
  logic                 out_stall;
  logic                 overlap_hit;
  pair_kind_t           pair_kind;

  collision_t predicted_collisions[$];
  int         error_count = 0;
  int         results_seen = 0;
  int         hits_seen = 0;
  int         kind_seen[3] = '{0, 0, 0};
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_left = 0;

  box_circle_pair_collision_test_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .first_is_circle  (first_is_circle),
    .first_x          (first_x),
    .first_y          (first_y),
    .first_width      (first_width),
    .first_height     (first_height),
    .first_radius     (first_radius),
    .second_is_circle (second_is_circle),
    .second_x         (second_x),
    .second_y         (second_y),
    .second_width     (second_width),
    .second_height    (second_height),
    .second_radius    (second_radius),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .overlap_hit      (overlap_hit),
    .pair_kind        (pair_kind)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // collision predictor
  // ---------------------------------------------------------------------------

  // strict squared-distance test, with the far-apart cut
  function automatic bit within_radius(longint dx, longint dy, longint rr);
    longint ax;
    longint ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax > FAR_LIMIT || ay > FAR_LIMIT) return 1'b0;
    return (ax * ax + ay * ay) < rr * rr;
  endfunction

  // nearest point of the box to the centre, then distance against r
  function automatic bit circle_meets_box(shape_t c, shape_t b);
    longint cx, cy, bx, by, px, py;
    cx = longint'(c.x);
    cy = longint'(c.y);
    bx = longint'(b.x);
    by = longint'(b.y);
    px = cx < bx ? bx : (cx > bx + longint'(b.width) ? bx + longint'(b.width) : cx);
    py = cy < by ? by : (cy > by + longint'(b.height) ? by + longint'(b.height) : cy);
    return within_radius(cx - px, cy - py, longint'(c.radius));
  endfunction

  function automatic collision_t predict_collision(shape_pair_t p);
    collision_t res;
    longint     x1, y1, x2, y2;
    x1 = longint'(p.a.x);
    y1 = longint'(p.a.y);
    x2 = longint'(p.b.x);
    y2 = longint'(p.b.y);
    if (p.a.is_circle && p.b.is_circle) begin
      res.kind = KIND_CIRCLE_CIRCLE;
      res.hit  = within_radius(x1 - x2, y1 - y2,
                               longint'(p.a.radius) + longint'(p.b.radius));
    end else if (p.a.is_circle) begin
      res.kind = KIND_BOX_CIRCLE;
      res.hit  = circle_meets_box(p.a, p.b);
    end else if (p.b.is_circle) begin
      res.kind = KIND_BOX_CIRCLE;
      res.hit  = circle_meets_box(p.b, p.a);
    end else begin
      res.kind = KIND_BOX_BOX;
      res.hit  = (x1 < x2 + longint'(p.b.width)) && (x1 + longint'(p.a.width) > x2) &&
                 (y1 < y2 + longint'(p.b.height)) && (y1 + longint'(p.a.height) > y2);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // shape builders and random generation
  // ---------------------------------------------------------------------------

  // unused fields carry noise so that the block must ignore them
  function automatic shape_t box_shape(int x, int y, int w, int h);
    shape_t s;
    s.is_circle = 1'b0;
    s.x         = CW'(x);
    s.y         = CW'(y);
    s.width     = SW'(w);
    s.height    = SW'(h);
    s.radius    = SW'($urandom);
    return s;
  endfunction

  function automatic shape_t circle_shape(int x, int y, int r);
    shape_t s;
    s.is_circle = 1'b1;
    s.x         = CW'(x);
    s.y         = CW'(y);
    s.width     = SW'($urandom);
    s.height    = SW'($urandom);
    s.radius    = SW'(r);
    return s;
  endfunction

  function automatic logic [SW-1:0] random_size(bit spread);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return spread ? SW'($urandom) : SW'($urandom_range(300));
    endcase
  endfunction

  // mostly shapes clustered near the origin so that hits are common
  function automatic shape_t random_shape(bit spread);
    shape_t s;
    s.is_circle = 1'($urandom_range(1));
    if (spread) begin
      s.x = CW'($urandom);
      s.y = CW'($urandom);
    end else begin
      s.x = CW'(int'($urandom_range(800)) - 400);
      s.y = CW'(int'($urandom_range(800)) - 400);
    end
    s.width  = random_size(spread);
    s.height = random_size(spread);
    s.radius = random_size(spread);
    return s;
  endfunction

  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    bit          spread;
    spread = ($urandom_range(3) == 0);
    p.a    = random_shape(spread);
    p.b    = random_shape(spread);
    return p;
  endfunction

  function automatic shape_pair_t make_pair(shape_t a, shape_t b);
    shape_pair_t p;
    p.a = a;
    p.b = b;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // item driver
  // ---------------------------------------------------------------------------

  // valid stays high straight into the next item unless an idle cycle is drawn
  task automatic send_pair(input shape_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    first_is_circle  <= p.a.is_circle;
    first_x          <= p.a.x;
    first_y          <= p.a.y;
    first_width      <= p.a.width;
    first_height     <= p.a.height;
    first_radius     <= p.a.radius;
    second_is_circle <= p.b.is_circle;
    second_x         <= p.b.x;
    second_y         <= p.b.y;
    second_width     <= p.b.width;
    second_height    <= p.b.height;
    second_radius    <= p.b.radius;
    in_valid         <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_collisions.push_back(predict_collision(p));
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_collisions.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // output side: stall generation and result check
  // ---------------------------------------------------------------------------

  // a requested hold-off is counted down here, otherwise random stalls
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    collision_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_collisions.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result item, expected none, got hit %0d kind %0d",
                 $time, overlap_hit, pair_kind);
      end else begin
        want = predicted_collisions.pop_front();
        if (overlap_hit !== want.hit) begin
          error_count++;
          $display("%0t: overlap_hit expected %0d got %0d", $time, want.hit, overlap_hit);
        end
        if (pair_kind !== want.kind) begin
          error_count++;
          $display("%0t: pair_kind expected %0d got %0d", $time, want.kind, pair_kind);
        end
        results_seen++;
        if (want.hit) hits_seen++;
        kind_seen[want.kind]++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // touching edges, zero sizes, widest coordinates, both box-circle orders
  task automatic test_directed_shapes();
    shape_pair_t cases[$];
    cases.push_back(make_pair(box_shape(0, 0, 10, 10), box_shape(5, 5, 10, 10)));
    cases.push_back(make_pair(box_shape(0, 0, 10, 10), box_shape(10, 0, 10, 10)));
    cases.push_back(make_pair(box_shape(0, 0, 10, 10), box_shape(0, 10, 10, 10)));
    cases.push_back(make_pair(box_shape(0, 0, 0, 10), box_shape(0, 0, 0, 10)));
    cases.push_back(make_pair(box_shape(0, 0, 0, 10), box_shape(-5, 0, 10, 10)));
    cases.push_back(make_pair(box_shape(-32768, -32768, 32767, 32767),
                              box_shape(32767, 32767, 32767, 32767)));
    cases.push_back(make_pair(box_shape(-32768, -32768, 32767, 32767),
                              box_shape(-1, -1, 1, 1)));
    cases.push_back(make_pair(box_shape(-32768, -32768, 32767, 32767),
                              box_shape(-2, -2, 1, 1)));
    // circles just touching and just overlapping
    cases.push_back(make_pair(circle_shape(0, 0, 5), circle_shape(3, 4, 0)));
    cases.push_back(make_pair(circle_shape(0, 0, 5), circle_shape(3, 4, 1)));
    cases.push_back(make_pair(circle_shape(0, 0, 0), circle_shape(0, 0, 0)));
    cases.push_back(make_pair(circle_shape(-32768, 0, 32767), circle_shape(32767, 0, 32767)));
    cases.push_back(make_pair(circle_shape(-32767, 0, 32767), circle_shape(32767, 0, 32767)));
    cases.push_back(make_pair(circle_shape(-32766, 0, 32767), circle_shape(32767, 0, 32767)));
    cases.push_back(make_pair(circle_shape(-32768, -32768, 32767),
                              circle_shape(32767, 32767, 32767)));
    // circle against box, centre inside, side, corner and zero radius
    cases.push_back(make_pair(circle_shape(50, 50, 10), box_shape(0, 0, 100, 100)));
    cases.push_back(make_pair(box_shape(0, 0, 100, 100), circle_shape(105, 50, 5)));
    cases.push_back(make_pair(box_shape(0, 0, 100, 100), circle_shape(105, 50, 6)));
    cases.push_back(make_pair(circle_shape(110, 110, 15), box_shape(0, 0, 100, 100)));
    cases.push_back(make_pair(circle_shape(110, 110, 14), box_shape(0, 0, 100, 100)));
    cases.push_back(make_pair(circle_shape(5, 5, 0), box_shape(0, 0, 10, 10)));
    cases.push_back(make_pair(box_shape(0, 0, 0, 0), circle_shape(0, 3, 4)));
    cases.push_back(make_pair(circle_shape(-32768, -32768, 32767),
                              box_shape(32767, 32767, 32767, 32767)));
    cases.push_back(make_pair(box_shape(-32768, 32767, 32767, 0),
                              circle_shape(32767, -32768, 32767)));
    send_idle_pct = 24;
    recv_idle_pct = 61;
    foreach (cases[i]) send_pair(cases[i]);
    wait_all_results();
  endtask

  task automatic test_random_pairs(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_pair(random_pair());
    wait_all_results();
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 120;
    repeat (20) send_pair(random_pair());
    wait_all_results();
  endtask

  // short bursts, each followed by a full drain before the next
  task automatic test_pause_and_resume();
    repeat (3) begin
      repeat ($urandom_range(8, 1)) send_pair(random_pair());
      wait_all_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    first_is_circle  <= 1'b0;
    first_x          <= '0;
    first_y          <= '0;
    first_width      <= '0;
    first_height     <= '0;
    first_radius     <= '0;
    second_is_circle <= 1'b0;
    second_x         <= '0;
    second_y         <= '0;
    second_width     <= '0;
    second_height    <= '0;
    second_radius    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_shapes();
    test_random_pairs(130, 24, 61);
    test_pause_and_resume();
    test_random_pairs(130, 61, 24);
    test_output_hold_off();
    test_random_pairs(130, 0, 0);

    // let any stray result show up before the verdict
    repeat (12) @(posedge clk);
    if (predicted_collisions.size() != 0) begin
      error_count++;
      $display("%0t: %0d result items never arrived", $time, predicted_collisions.size());
    end
    $display("checked %0d results: %0d box-box, %0d box-circle, %0d circle-circle, %0d hits",
             results_seen, kind_seen[KIND_BOX_BOX], kind_seen[KIND_BOX_CIRCLE],
             kind_seen[KIND_CIRCLE_CIRCLE], hits_seen);
    $display("traffic: sender and receiver idling both ways round, no idling, hold-off, drains");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
